FILE: rtl/row_profile_placement_dp_assert.svh
// Assertion macros for the row profile placement block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ROW_PROFILE_PLACEMENT_DP_ASSERT_SVH
`define ROW_PROFILE_PLACEMENT_DP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RPP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent in the next cycle.
`define RPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rpp_pkg.sv
// Shared types and constants for the row profile placement block.
// No dependencies.
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int unsigned MaxCols     = 10;
  localparam int unsigned MaxPatterns = 64;
  localparam int unsigned ColW        = 4;
  localparam int unsigned MaskW       = MaxCols;
  localparam int unsigned PatAw       = $clog2(MaxPatterns);
  localparam int unsigned CntW        = $clog2(MaxPatterns + 1);
  localparam int unsigned WeightW     = 3;
  localparam int unsigned ScoreW      = 10;
  localparam int unsigned ScoreAw     = 1 + 2 * PatAw;
  localparam int unsigned ColReset    = 10;
  localparam logic [ScoreW-1:0] ScoreMax = '1;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] count;
  } pat_status_t;

  typedef struct packed {
    logic [MaskW-1:0]   pattern;
    logic [WeightW-1:0] weight;
  } pat_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_I_RD,
    S_I_LAT,
    S_J_RD,
    S_J_LAT,
    S_K,
    S_K_DRAIN,
    S_WR,
    S_DONE
  } state_e;

  function automatic logic [WeightW-1:0] pop_count(input logic [MaskW-1:0] v);
    logic [WeightW-1:0] c;
    c = '0;
    for (int b = 0; b < MaskW; b++) begin
      c = c + WeightW'(v[b]);
    end
    return c;
  endfunction

endpackage

FILE: rtl/rpp_pat_table.sv
// Legal row pattern table: builder sweep plus a 1R1W synchronous memory.
// Depends on rpp_pkg.
`timescale 1ns / 1ps

module rpp_pat_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpp_pkg::ColW-1:0]      col_count_i,
  input  logic [rpp_pkg::PatAw-1:0]     rd_addr_i,
  output rpp_pkg::pat_entry_t           rd_data_o,
  output rpp_pkg::pat_status_t          status_o
);

  localparam int unsigned XW = rpp_pkg::MaskW + 1;

  rpp_pkg::pat_entry_t mem [rpp_pkg::MaxPatterns];
  rpp_pkg::pat_entry_t rd_data_q;

  logic                      busy_q, busy_d;
  logic [XW-1:0]             x_q, x_d;
  logic [rpp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [XW-1:0]             lim;
  logic [rpp_pkg::MaskW-1:0] xv;
  logic                      legal, room, wr_en;
  logic [rpp_pkg::ColW-1:0]  cols;

  always_comb begin
    cols  = (col_count_i > rpp_pkg::ColW'(rpp_pkg::MaxCols)) ?
            rpp_pkg::ColW'(rpp_pkg::MaxCols) : col_count_i;
    lim   = XW'(1) << cols;
    xv    = x_q[rpp_pkg::MaskW-1:0];
    legal = ((xv & (xv >> 1)) == '0) && ((xv & (xv >> 2)) == '0);
    room  = cnt_q < rpp_pkg::CntW'(rpp_pkg::MaxPatterns);
    wr_en = busy_q && legal && room;
    busy_d = busy_q;
    x_d    = x_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = '0;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (wr_en) cnt_d = cnt_q + 1'b1;
      x_d = x_q + 1'b1;
      if ((x_q == lim - 1'b1) || !room) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      x_q    <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      x_q    <= x_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[rpp_pkg::PatAw-1:0]] <= '{pattern: xv, weight: rpp_pkg::pop_count(xv)};
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o       = rd_data_q;
  assign status_o.busy   = busy_q;
  assign status_o.count  = cnt_q;

endmodule

FILE: rtl/rpp_score_ram.sv
// Ping-pong score store: both banks in one 1R1W synchronous memory.
// Depends on rpp_pkg.
`timescale 1ns / 1ps

module rpp_score_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rpp_pkg::ScoreAw-1:0] waddr_i,
  input  logic [rpp_pkg::ScoreW-1:0]  wdata_i,
  input  logic [rpp_pkg::ScoreAw-1:0] raddr_i,
  output logic [rpp_pkg::ScoreW-1:0]  rdata_o
);

  logic [rpp_pkg::ScoreW-1:0] mem [2**rpp_pkg::ScoreAw];
  logic [rpp_pkg::ScoreW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/row_profile_placement_dp.sv
// Row profile placement DP: the row sequencer over the pattern table and scores.
// Depends on rpp_pkg, rpp_pat_table, rpp_score_ram and the assertion header.
//
// Usage:
//   Write col_count through cfg_we_i/cfg_wdata_i while idle; this rebuilds the
//   pattern table and starts a new grid.
//   Feed rows on the input channel (valid/stall). One beat per row.
//   A row with last_row_i set produces one beat on the output channel holding
//   the best mark count; other rows produce nothing.
// Operation:
//   With n legal patterns each row runs a triple loop over i, j and k; a
//   blocked (i, j) pair skips its k sweep. The k sweep is one read of the
//   pattern table and one score read per cycle, so this triple loop sets
//   the run time (n = 60 at the full ten columns).
//   Rows are handled one at a time; in_stall_o is high while a row or a
//   table build is in progress.
// Reset:
//   Width goes to 10 and the table is built; no rows are taken meanwhile.
// Output stall:
//   The result sits in an output register; the next row is accepted and
//   worked while it waits, and only a further result waits for it to drain.
`timescale 1ns / 1ps

module row_profile_placement_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpp_pkg::ColW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rpp_pkg::MaskW-1:0]    row_mask_i,
  input  logic                         last_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rpp_pkg::ScoreW-1:0]   max_placed_o
);

  localparam logic [rpp_pkg::MaskW-1:0] AllBlocked = '1;

  rpp_pkg::state_e      state_q, state_d;
  rpp_pkg::pat_status_t pt_status;
  rpp_pkg::pat_entry_t  pt_rd;

  logic [rpp_pkg::ColW-1:0]    col_q;
  logic [rpp_pkg::MaskW-1:0]   old0_q, old1_q, mask_q, m1_q, m2_q, pi_q, pj_q;
  logic [1:0]                  rows_q, rows_live_q;
  logic                        last_q, bank_q, ok_q, rd_v_q;
  logic [rpp_pkg::WeightW-1:0] wi_q;
  logic [rpp_pkg::CntW-1:0]    i_q, j_q, k_q, i_d, j_d, k_d, n;
  logic [rpp_pkg::ScoreW-1:0]  top_q, top_d, best_q, best_d, out_q;
  logic                        out_valid_q;

  logic [rpp_pkg::PatAw-1:0]   pt_addr;
  logic [rpp_pkg::ScoreAw-1:0] s_raddr, s_waddr;
  logic [rpp_pkg::ScoreW-1:0]  s_rdata, s_wdata, v;
  logic                        s_we, accept, k_legal, commit, ok_d;
  logic [rpp_pkg::ScoreW:0]    sum;

  assign n      = pt_status.count;
  assign accept = in_valid_i && !in_stall_o;
  assign commit = (state_q == rpp_pkg::S_DONE) && !(last_q && out_valid_q && out_stall_i);

  rpp_pat_table u_pat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_we_i),
    .col_count_i(cfg_we_i ? cfg_wdata_i : col_q),
    .rd_addr_i  (pt_addr),
    .rd_data_o  (pt_rd),
    .status_o   (pt_status)
  );

  rpp_score_ram u_score (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpp_pkg::S_IDLE:    if (accept) state_d = rpp_pkg::S_I_RD;
      rpp_pkg::S_I_RD:    state_d = rpp_pkg::S_I_LAT;
      rpp_pkg::S_I_LAT:   state_d = rpp_pkg::S_J_RD;
      rpp_pkg::S_J_RD:    state_d = rpp_pkg::S_J_LAT;
      rpp_pkg::S_J_LAT:   state_d = ok_d ? rpp_pkg::S_K : rpp_pkg::S_WR;
      rpp_pkg::S_K:       if (k_q == n - 1'b1) state_d = rpp_pkg::S_K_DRAIN;
      rpp_pkg::S_K_DRAIN: state_d = rpp_pkg::S_WR;
      rpp_pkg::S_WR: begin
        if (j_q != n - 1'b1)      state_d = rpp_pkg::S_J_RD;
        else if (i_q != n - 1'b1) state_d = rpp_pkg::S_I_RD;
        else                      state_d = rpp_pkg::S_DONE;
      end
      rpp_pkg::S_DONE:    if (commit) state_d = rpp_pkg::S_IDLE;
      default:            state_d = rpp_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o = (state_q != rpp_pkg::S_IDLE) || pt_status.busy;
    pt_addr    = k_q[rpp_pkg::PatAw-1:0];
    case (state_q)
      rpp_pkg::S_I_RD: pt_addr = i_q[rpp_pkg::PatAw-1:0];
      rpp_pkg::S_J_RD: pt_addr = j_q[rpp_pkg::PatAw-1:0];
      default:         pt_addr = k_q[rpp_pkg::PatAw-1:0];
    endcase
    s_raddr = {~bank_q, j_q[rpp_pkg::PatAw-1:0], k_q[rpp_pkg::PatAw-1:0]};
    s_waddr = {bank_q, i_q[rpp_pkg::PatAw-1:0], j_q[rpp_pkg::PatAw-1:0]};
    ok_d    = ((pi_q & mask_q) == '0) && ((pt_rd.pattern & m1_q) == '0) &&
              ((pi_q & pt_rd.pattern) == '0);

    // previous-row scores count as zero at the start of a grid
    v       = (rows_live_q == 2'd0) ? '0 : s_rdata;
    k_legal = ((pt_rd.pattern & m2_q) == '0) && ((pj_q & pt_rd.pattern) == '0) &&
              ((pi_q & pt_rd.pattern) == '0);
    top_d = top_q;
    if (state_q == rpp_pkg::S_J_LAT) top_d = '0;
    else if (rd_v_q && k_legal && (v > top_q)) top_d = v;

    sum     = {1'b0, top_q} + (rpp_pkg::ScoreW + 1)'(wi_q);
    s_wdata = !ok_q ? '0 : (sum[rpp_pkg::ScoreW] ? rpp_pkg::ScoreMax
                                                 : sum[rpp_pkg::ScoreW-1:0]);
    s_we    = (state_q == rpp_pkg::S_WR);

    best_d = best_q;
    if (accept) best_d = '0;
    else if (s_we && (s_wdata > best_q)) best_d = s_wdata;

    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    case (state_q)
      rpp_pkg::S_IDLE:  i_d = '0;
      rpp_pkg::S_I_LAT: j_d = '0;
      rpp_pkg::S_J_LAT: k_d = '0;
      rpp_pkg::S_K:     k_d = k_q + 1'b1;
      rpp_pkg::S_WR: begin
        if (j_q != n - 1'b1) j_d = j_q + 1'b1;
        else                 i_d = i_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpp_pkg::S_IDLE;
      col_q       <= rpp_pkg::ColW'(rpp_pkg::ColReset);
      old0_q      <= '0;
      old1_q      <= '0;
      rows_q      <= '0;
      bank_q      <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == rpp_pkg::S_K);
      if (commit && last_q && !cfg_we_i) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        col_q  <= cfg_wdata_i;
        old0_q <= '0;
        old1_q <= '0;
        rows_q <= '0;
      end else if (commit) begin
        bank_q <= ~bank_q;
        if (last_q) begin
          old0_q <= '0;
          old1_q <= '0;
          rows_q <= '0;
        end else begin
          old0_q <= mask_q;
          old1_q <= old0_q;
          if (rows_q != 2'd2) rows_q <= rows_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    top_q  <= top_d;
    best_q <= best_d;
    if (accept) begin
      mask_q      <= row_mask_i;
      last_q      <= last_row_i;
      m1_q        <= (rows_q >= 2'd1) ? old0_q : AllBlocked;
      m2_q        <= (rows_q >= 2'd2) ? old1_q : AllBlocked;
      rows_live_q <= rows_q;
    end
    if (state_q == rpp_pkg::S_I_LAT) begin
      pi_q <= pt_rd.pattern;
      wi_q <= pt_rd.weight;
    end
    if (state_q == rpp_pkg::S_J_LAT) begin
      pj_q <= pt_rd.pattern;
      ok_q <= ok_d;
    end
    if (commit && last_q) out_q <= best_q;
  end

  assign out_valid_o  = out_valid_q;
  assign max_placed_o = out_q;

`include "row_profile_placement_dp_assert.svh"

  `RPP_ASSERT(a_build_stalls, pt_status.busy, in_stall_o, "row accepted during table build")
  `RPP_ASSERT(a_k_in_range, state_q == rpp_pkg::S_K, k_q < n, "k sweep past table")
  `RPP_ASSERT_NEXT(a_result_from_done, !out_valid_q && commit && last_q, out_valid_o,
                   "last row finished without a result")

endmodule

FILE: bench/tb.sv
// Testbench for row_profile_placement_dp: drives rows with random bursts and gaps,
// stalls the result channel, and checks every result against a built-in predictor.
// Depends on rpp_pkg and the row_profile_placement_dp RTL.
`timescale 1ns / 1ps

module tb;

  // Row-by-row placement predictor and store of expected best counts.
  class placement_board;
    logic [rpp_pkg::MaskW-1:0]   pat_tbl[rpp_pkg::MaxPatterns];
    logic [rpp_pkg::WeightW-1:0] pat_wt[rpp_pkg::MaxPatterns];
    int unsigned                 pat_cnt;
    logic [rpp_pkg::ScoreW-1:0]  score_old[rpp_pkg::MaxPatterns*rpp_pkg::MaxPatterns];
    logic [rpp_pkg::ScoreW-1:0]  score_new[rpp_pkg::MaxPatterns*rpp_pkg::MaxPatterns];
    logic [rpp_pkg::MaskW-1:0]   mask_hist[2];
    int unsigned                 rows_in;
    logic [rpp_pkg::ScoreW-1:0]  best_q[$];
    int unsigned                 errors;

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void clear_grid();
      foreach (score_old[a]) begin
        score_old[a] = '0;
        score_new[a] = '0;
      end
      mask_hist[0] = '0;
      mask_hist[1] = '0;
      rows_in = 0;
    endfunction

    function void set_width(logic [rpp_pkg::ColW-1:0] w);
      int unsigned cols, x, c;
      cols = (w > rpp_pkg::MaxCols) ? rpp_pkg::MaxCols : w;
      pat_cnt = 0;
      for (x = 0; x < (1 << cols) && pat_cnt < rpp_pkg::MaxPatterns; x++) begin
        if ((x & (x >> 1)) == 0 && (x & (x >> 2)) == 0) begin
          c = 0;
          for (int b = 0; b < rpp_pkg::MaskW; b++) c += (x >> b) & 1;
          pat_tbl[pat_cnt] = rpp_pkg::MaskW'(x);
          pat_wt[pat_cnt] = rpp_pkg::WeightW'(c);
          pat_cnt++;
        end
      end
      clear_grid();
    endfunction

    function void note_row(logic [rpp_pkg::MaskW-1:0] mask, logic last);
      logic [rpp_pkg::MaskW-1:0] m1, m2, pi, pj, pk;
      int unsigned top, best;
      m1 = (rows_in >= 1) ? mask_hist[0] : '1;
      m2 = (rows_in >= 2) ? mask_hist[1] : '1;
      foreach (score_new[a]) score_new[a] = '0;
      for (int i = 0; i < pat_cnt; i++) begin
        pi = pat_tbl[i];
        if ((pi & mask) != 0) continue;
        for (int j = 0; j < pat_cnt; j++) begin
          pj = pat_tbl[j];
          if ((pj & m1) != 0 || (pi & pj) != 0) continue;
          top = 0;
          for (int k = 0; k < pat_cnt; k++) begin
            pk = pat_tbl[k];
            if ((pk & m2) != 0 || (pj & pk) != 0 || (pi & pk) != 0) continue;
            if (score_old[j*rpp_pkg::MaxPatterns+k] > top)
              top = score_old[j*rpp_pkg::MaxPatterns+k];
          end
          top += pat_wt[i];
          if (top > rpp_pkg::ScoreMax) top = rpp_pkg::ScoreMax;
          score_new[i*rpp_pkg::MaxPatterns+j] = rpp_pkg::ScoreW'(top);
        end
      end
      score_old = score_new;
      mask_hist[1] = mask_hist[0];
      mask_hist[0] = mask;
      if (rows_in < 2) rows_in++;
      if (last) begin
        best = 0;
        foreach (score_new[a]) if (score_new[a] > best) best = score_new[a];
        best_q.push_back(rpp_pkg::ScoreW'(best));
        clear_grid();
      end
    endfunction

    task check_result(logic [rpp_pkg::ScoreW-1:0] got);
      if (best_q.size() == 0) begin
        report($sformatf("unexpected result max_placed=%0d", got));
      end else if (best_q[0] !== got) begin
        report($sformatf("max_placed got %0d want %0d", got, best_q[0]));
        void'(best_q.pop_front());
      end else begin
        void'(best_q.pop_front());
      end
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [rpp_pkg::ColW-1:0]    cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [rpp_pkg::MaskW-1:0]   row_mask_i = '0;
  logic                        last_row_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [rpp_pkg::ScoreW-1:0]  max_placed_o;

  placement_board board = new();
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  row_profile_placement_dp i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_mask_i  (row_mask_i),
    .last_row_i  (last_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .max_placed_o(max_placed_o)
  );

  // Result side: check accepted beats, stall on a mode that changes now and then.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 20000000) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(max_placed_o);
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task send_row(logic [rpp_pkg::MaskW-1:0] mask, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    row_mask_i <= mask;
    last_row_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_row(mask, last);
  endtask

  // Width change only once the block is idle and every result is back.
  task set_cols(logic [rpp_pkg::ColW-1:0] w);
    in_valid_i <= 1'b0;
    while (board.best_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_width(w);
  endtask

  initial begin
    int unsigned rows, w;
    board.set_width(rpp_pkg::ColW'(rpp_pkg::ColReset));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset width, all-open and all-blocked rows
    send_row(10'h000, 1'b1);
    send_row(10'h3FF, 1'b0);
    send_row(10'h000, 1'b0);
    send_row(10'h2AA, 1'b1);
    set_cols(4'd0);            // zero width: only the empty pattern
    send_row(10'h000, 1'b1);
    send_row(10'h3FF, 1'b0);
    send_row(10'h000, 1'b1);
    set_cols(4'd15);           // saturates to ten columns
    send_row(10'h000, 1'b0);
    send_row(10'h155, 1'b1);
    set_cols(4'd1);            // vertical spacing in a single column
    repeat (4) send_row(10'h000, 1'b0);
    send_row(10'h000, 1'b1);
    set_cols(4'd10);           // one deep row at full width
    send_row(10'h000, 1'b0);
    send_row(10'h000, 1'b0);
    send_row(10'h0F0, 1'b1);
    set_cols(4'd4);            // mask bits above the width are ignored
    send_row(10'h3F0, 1'b0);
    send_row(10'h3F5, 1'b1);

    // random grids at small widths
    for (int g = 0; g < 24; g++) begin
      w = $urandom_range(0, 7);
      set_cols(rpp_pkg::ColW'(w));
      rows = $urandom_range(1, 6);
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_row(rpp_pkg::MaskW'($urandom), r == rows - 1);
        end else begin
          send_row(rpp_pkg::MaskW'($urandom) & rpp_pkg::MaskW'($urandom) &
                   rpp_pkg::MaskW'($urandom), r == rows - 1);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (board.best_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rpp_pkg.sv
rtl/rpp_pat_table.sv
rtl/rpp_score_ram.sv
rtl/row_profile_placement_dp.sv
bench/tb.sv
